>>> rtl/core/dsc_pkg.sv
// Shared types, field widths and density constants for the dust sample classifier.
package dsc_pkg;

  // Field widths.
  localparam int ADC_W   = 10;
  localparam int DENS_W  = 21;
  localparam int LEVEL_W = 8;
  localparam int ADC_MAX = 1023;

  // Stream data widths, padded to whole bytes.
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 56;

  // Default window length of the moving average.
  localparam int HISTORY_DEPTH_DEF = 10;

  // Density in ug/m3 with 7 fractional bits: slope * filt - offset.
  localparam int unsigned DENS_SLOPE      = 1375;
  localparam int unsigned DENS_OFFSET     = 10240;
  localparam int unsigned DENS_MIN_SAMPLE = 8;

  // Upper band limits, in the same Q7 scale as the density.
  localparam logic [DENS_W-1:0] LIM_EXCELLENT = DENS_W'(36 * 128);
  localparam logic [DENS_W-1:0] LIM_GOOD      = DENS_W'(76 * 128);
  localparam logic [DENS_W-1:0] LIM_AVERAGE   = DENS_W'(116 * 128);
  localparam logic [DENS_W-1:0] LIM_LIGHT     = DENS_W'(151 * 128);
  localparam logic [DENS_W-1:0] LIM_MID       = DENS_W'(251 * 128);
  localparam logic [DENS_W-1:0] LIM_HEAVY     = DENS_W'(501 * 128);

  // Above this density the LEDs saturate and the buzzer sounds.
  localparam logic [DENS_W-1:0] ALARM_Q7 = DENS_W'(500 * 128);

  // Air-quality bands; BAND_NONE marks that no band is remembered.
  typedef enum logic [2:0] {
    BAND_EXCELLENT = 3'd0,
    BAND_GOOD      = 3'd1,
    BAND_AVERAGE   = 3'd2,
    BAND_LIGHT     = 3'd3,
    BAND_MID       = 3'd4,
    BAND_HEAVY     = 3'd5,
    BAND_OUT       = 3'd6,
    BAND_NONE      = 3'd7
  } band_t;

  // Filtered sample handed from the averaging window to the grading stages.
  typedef struct packed {
    logic             forget;
    logic [ADC_W-1:0] filt;
  } filt_req_t;

  // One finished result.
  typedef struct packed {
    logic               buzzer;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] red;
    logic               changed;
    band_t              band;
    logic [DENS_W-1:0]  dens;
    logic [ADC_W-1:0]   filt;
  } result_t;

endpackage

>>> rtl/core/dsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/dsc_window.sv
// Moving-average window: history ring, running sum and division by the window length.
module dsc_window #(
  parameter int HISTORY_DEPTH = dsc_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [dsc_pkg::ADC_W-1:0]  sample,
  input  logic                       forget,
  output logic                       out_valid,
  input  logic                       out_ready,
  output dsc_pkg::filt_req_t         out
);
  import dsc_pkg::*;

  localparam int AW      = $clog2(HISTORY_DEPTH);
  localparam int SUM_W   = $clog2(ADC_MAX * HISTORY_DEPTH + 1);
  // Reciprocal that gives an exact floor quotient for every SUM_W-bit sum.
  localparam int DIV_S   = SUM_W + $clog2(HISTORY_DEPTH);
  localparam longint unsigned RECIP =
    ((64'd1 << DIV_S) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH);
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam logic [AW-1:0] LAST_SLOT = AW'(HISTORY_DEPTH - 1);

  logic              primed;
  logic              wrapped;
  logic [AW-1:0]     slot;
  logic [AW-1:0]     slot_next;
  logic [ADC_W-1:0]  first_sample;
  logic [ADC_W-1:0]  hist_rd;
  logic [ADC_W-1:0]  old_sample;
  logic [SUM_W-1:0]  window_sum;
  logic [SUM_W-1:0]  sum_step;
  logic [SUM_W-1:0]  sum_prime;
  logic              sum_valid;
  logic              sum_forget;
  logic [PROD_W-1:0] prod;
  logic              accept;
  logic              adv_out;
  logic              adv_sum;

  // Per-stage advance: a stage loads when it is empty or its contents move on.
  assign adv_out  = !out_valid || out_ready;
  assign adv_sum  = !sum_valid || adv_out;
  assign in_ready = adv_sum;
  assign accept   = in_valid && adv_sum;

  // Ring slot of the oldest entry; it only moves once the window is primed.
  always_comb begin
    slot_next = slot;
    if (accept && primed) begin
      slot_next = (slot == LAST_SLOT) ? '0 : slot + 1'b1;
    end
  end

  // Slots not yet written since priming still hold the first sample.
  assign old_sample = wrapped ? hist_rd : first_sample;
  assign sum_step   = window_sum - SUM_W'(old_sample) + SUM_W'(sample);
  assign sum_prime  = SUM_W'(sample) * SUM_W'(HISTORY_DEPTH);

  // Truncated mean by multiplication with the reciprocal.
  assign prod = PROD_W'(window_sum) * PROD_W'(RECIP);

  // The read address runs one slot ahead so the oldest entry is ready next cycle.
  dsc_ram #(
    .WIDTH (ADC_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (accept && primed),
    .waddr (slot),
    .wdata (sample),
    .raddr (slot_next),
    .rdata (hist_rd)
  );

  // Control state and stage valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      primed    <= 1'b0;
      wrapped   <= 1'b0;
      slot      <= '0;
      sum_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        primed <= 1'b1;
        slot   <= slot_next;
        if (primed && slot == LAST_SLOT) begin
          wrapped <= 1'b1;
        end
      end
      if (adv_sum) begin
        sum_valid <= in_valid;
      end
      if (adv_out) begin
        out_valid <= sum_valid;
      end
    end
  end

  // Running sum, first sample and the quotient stage.
  always_ff @(posedge clk) begin
    if (accept) begin
      window_sum <= primed ? sum_step : sum_prime;
      sum_forget <= forget;
      if (!primed) begin
        first_sample <= sample;
      end
    end
    if (adv_out && sum_valid) begin
      out.filt   <= prod[DIV_S +: ADC_W];
      out.forget <= sum_forget;
    end
  end

endmodule

>>> rtl/core/dsc_grade.sv
// Density scaling, band classification with change detection, LED levels and buzzer.
module dsc_grade (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  dsc_pkg::filt_req_t in,
  output logic               out_valid,
  input  logic               out_ready,
  output dsc_pkg::result_t   out
);
  import dsc_pkg::*;

  // Integer density is below 512 whenever the LEDs are not saturated.
  localparam int X_W     = 9;
  // Red: floor(x * 31 / 100), exact reciprocal for 14-bit numerators.
  localparam int RNUM_W  = X_W + 5;
  localparam int RED_S   = RNUM_W + 7;
  localparam int unsigned RED_RECIP = ((32'd1 << RED_S) + 32'd99) / 32'd100;
  localparam int RRECIP_W = $clog2(RED_RECIP + 1);
  localparam int RPROD_W = RNUM_W + RRECIP_W;
  // Green: floor(2x / 5), exact reciprocal for 10-bit numerators.
  localparam int GNUM_W  = X_W + 1;
  localparam int GRN_S   = GNUM_W + 3;
  localparam int unsigned GRN_RECIP = ((32'd1 << GRN_S) + 32'd4) / 32'd5;
  localparam int GRECIP_W = $clog2(GRN_RECIP + 1);
  localparam int GPROD_W = GNUM_W + GRECIP_W;

  localparam logic [LEVEL_W-1:0] RED_BASE   = LEVEL_W'(100);
  localparam logic [LEVEL_W-1:0] GREEN_BASE = LEVEL_W'(200);
  localparam logic [LEVEL_W-1:0] LEVEL_FULL = '1;

  logic               dens_valid;
  logic [DENS_W-1:0]  dens;
  logic [ADC_W-1:0]   dens_filt;
  logic               dens_forget;
  logic [DENS_W-1:0]  scaled;
  logic [DENS_W-1:0]  dens_c;
  band_t              band_c;
  band_t              last_band;
  band_t              prev_band;
  logic               alarm;
  logic [X_W-1:0]     x;
  logic [RNUM_W-1:0]  red_num;
  logic [RPROD_W-1:0] red_prod;
  logic [GNUM_W-1:0]  grn_num;
  logic [GPROD_W-1:0] grn_prod;
  result_t            res;
  logic               adv_out;
  logic               adv_dens;

  assign adv_out  = !out_valid || out_ready;
  assign adv_dens = !dens_valid || adv_out;
  assign in_ready = adv_dens;

  // Density stage: one constant multiply and the offset.
  assign scaled = DENS_W'(in.filt) * DENS_W'(DENS_SLOPE);
  assign dens_c = (in.filt >= ADC_W'(DENS_MIN_SAMPLE)) ? scaled - DENS_W'(DENS_OFFSET) : '0;

  // Band classification; zero density counts as out of range.
  always_comb begin
    if (dens == '0) begin
      band_c = BAND_OUT;
    end else if (dens < LIM_EXCELLENT) begin
      band_c = BAND_EXCELLENT;
    end else if (dens < LIM_GOOD) begin
      band_c = BAND_GOOD;
    end else if (dens < LIM_AVERAGE) begin
      band_c = BAND_AVERAGE;
    end else if (dens < LIM_LIGHT) begin
      band_c = BAND_LIGHT;
    end else if (dens < LIM_MID) begin
      band_c = BAND_MID;
    end else if (dens < LIM_HEAVY) begin
      band_c = BAND_HEAVY;
    end else begin
      band_c = BAND_OUT;
    end
  end

  // A forget request drops the remembered band, so the change flag is forced.
  assign prev_band = dens_forget ? BAND_NONE : last_band;

  // LED levels from the integer density.
  assign alarm    = dens > ALARM_Q7;
  assign x        = dens[7 +: X_W];
  assign red_num  = {x, 5'b0} - RNUM_W'(x);
  assign red_prod = RPROD_W'(red_num) * RPROD_W'(RED_RECIP);
  assign grn_num  = {x, 1'b0};
  assign grn_prod = GPROD_W'(grn_num) * GPROD_W'(GRN_RECIP);

  always_comb begin
    res.filt    = dens_filt;
    res.dens    = dens;
    res.band    = band_c;
    res.changed = (band_c != prev_band);
    res.buzzer  = alarm;
    if (alarm) begin
      res.red   = LEVEL_FULL;
      res.green = '0;
    end else begin
      res.red   = RED_BASE + red_prod[RED_S +: LEVEL_W];
      res.green = GREEN_BASE - grn_prod[GRN_S +: LEVEL_W];
    end
  end

  // Control state: stage valid flags and the remembered band.
  always_ff @(posedge clk) begin
    if (rst) begin
      dens_valid <= 1'b0;
      out_valid  <= 1'b0;
      last_band  <= BAND_NONE;
    end else begin
      if (adv_dens) begin
        dens_valid <= in_valid;
      end
      if (adv_out) begin
        out_valid <= dens_valid;
        if (dens_valid) begin
          last_band <= band_c;
        end
      end
    end
  end

  // Density and result registers.
  always_ff @(posedge clk) begin
    if (adv_dens && in_valid) begin
      dens        <= dens_c;
      dens_filt   <= in.filt;
      dens_forget <= in.forget;
    end
    if (adv_out && dens_valid) begin
      out <= res;
    end
  end

endmodule

>>> rtl/core/dust_sample_classifier_core.sv
// Top level of the dust sample classifier: stream ports around window and grading.
//
//  Channel   Direction  Signals                     Payload
//  s_        in         s_tvalid s_tready s_tdata   adc_sample, forget_band
//  m_        out        m_tvalid m_tready m_tdata   filt, density, band, changed, LEDs, buzzer
//
// One request is accepted per cycle unless back pressure has filled the stages; a
// result is registered in turn in the running sum, mean, density and result register.
// The history ring lives in a RAM with a registered read port that is addressed
// one slot ahead; slots not yet written after the first sample read as that sample.
// Reset clears control state only and needs no clearing pass.
// Each of the four stages holds under back pressure and a stage frees as soon as
// its contents move on, so requests keep flowing until every stage is full.
module dust_sample_classifier_core #(
  parameter int HISTORY_DEPTH = dsc_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [9:0] adc_sample, [10] forget_band, [15:11] zero
  input  logic [dsc_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [9:0] filtered_sample, [30:10] density_q7, [33:31] band, [34] band_changed,
  // [42:35] red_level, [50:43] green_level, [51] buzzer_on, [55:52] zero
  output logic [dsc_pkg::M_TDATA_W-1:0] m_tdata
);
  import dsc_pkg::*;

  filt_req_t filt_req;
  logic      filt_valid;
  logic      filt_ready;
  result_t   res;

  dsc_window #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .sample    (s_tdata[ADC_W-1:0]),
    .forget    (s_tdata[ADC_W]),
    .out_valid (filt_valid),
    .out_ready (filt_ready),
    .out       (filt_req)
  );

  dsc_grade u_grade (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (filt_valid),
    .in_ready  (filt_ready),
    .in        (filt_req),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out       (res)
  );

  // Result fields packed from the lowest bit up.
  assign m_tdata = {(M_TDATA_W - $bits(result_t))'(0), res};

endmodule

>>> rtl/core/dsc_checker.sv
// Port-level checks of the dust sample classifier, bound to its top level.
module dsc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [dsc_pkg::S_TDATA_W-1:0] s_tdata,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [dsc_pkg::M_TDATA_W-1:0] m_tdata
);
  import dsc_pkg::*;

  logic [ADC_W-1:0]   filt;
  logic [DENS_W-1:0]  dens;
  logic [2:0]         band;
  logic [LEVEL_W-1:0] red;
  logic [LEVEL_W-1:0] green;
  logic               buzz;
  logic [DENS_W-1:0]  dens_exp;
  logic               s_used;

  assign filt   = m_tdata[9:0];
  assign dens   = m_tdata[30:10];
  assign band   = m_tdata[33:31];
  assign red    = m_tdata[42:35];
  assign green  = m_tdata[50:43];
  assign buzz   = m_tdata[51];
  assign s_used = s_tvalid && s_tready && (s_tdata[0] || !s_tdata[0]);
  assign dens_exp = (filt >= ADC_W'(DENS_MIN_SAMPLE)) ?
                    DENS_W'(filt) * DENS_W'(DENS_SLOPE) - DENS_W'(DENS_OFFSET) : '0;

  // A stalled result stays on the port unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // The density follows from the filtered sample shown beside it.
  a_dens: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> dens == dens_exp)
    else $error("density does not match filtered sample");

  // Out of range exactly for zero density or at or above the heavy limit.
  a_band: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((band == BAND_OUT) == (dens == '0 || dens >= LIM_HEAVY)))
    else $error("band inconsistent with density");

  // Alarm saturates the LEDs and sounds the buzzer.
  a_alarm: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (buzz == (dens > ALARM_Q7)) &&
                 (!buzz || (red == 8'd255 && green == 8'd0)) &&
                 (buzz || (red >= 8'd100 && green <= 8'd200)))
    else $error("alarm outputs inconsistent");

  // Right after reset the block is ready to take a request.
  a_ready: assert property (@(posedge clk)
    $past(rst) && !rst |-> s_tready || s_used)
    else $error("not ready after reset");

endmodule

bind dust_sample_classifier_core dsc_checker u_dsc_checker (.*);
